[hdl/mbthd_pkg.sv]
// Package for the multiplexed button tap/hold detector.
// Holds the request and result structs, configuration types and register codes.
// No dependencies.
package mbthd_pkg;

    localparam int CHANNELS_DEF   = 8;
    localparam int TIME_WIDTH_DEF = 32;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;

    typedef enum logic {
        EVT_TAP  = 1'b0,
        EVT_HOLD = 1'b1
    } evt_kind_t;

    typedef enum logic [0:0] {
        REG_MIN_TAP  = 1'b0,
        REG_MIN_HOLD = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]  channel;
        logic        pressed;
        logic [31:0] now_ticks;
    } sample_t;

    typedef struct packed {
        evt_kind_t   event_kind;
        logic [2:0]  event_channel;
        logic [31:0] duration_ticks;
    } result_t;

    typedef struct packed {
        logic [31:0] min_tap_ticks;
        logic [31:0] min_hold_ticks;
    } cfg_t;

endpackage

[hdl/muxed_button_tap_hold_detector.sv]
// Top level of the multiplexed button tap/hold detector.
// Depends on mbthd_pkg and mbthd_chan_bank.
//
// Usage: each sample request carries one scan slot of the button multiplexer
// (selected channel, its pressed level and a free-running timestamp). The block
// keeps per-channel level, hold-pending and reference time, and raises at most
// one result per request: a tap on a qualified release or a hold once a press
// has lasted min_hold_ticks.
// Channels: sample_valid/sample_stall/sample_data in, result_valid/
// result_stall/result_data out; a request moves when valid is high and stall
// is low. Configuration is written over the APB-style port (min_tap_ticks at
// 0x0, min_hold_ticks at 0x4); the user must write it only while the block is
// idle, which the block itself does not enforce.
// A taken request sits in the input register; the state update then writes any
// result into the result register, from which it is offered.
// Throughput: one request per cycle while no stalled result is held.
// When the receiver stalls, the result register holds; the one request behind
// it waits in the input register and further requests see sample_stall.
// Reset clears all channel state and both thresholds to zero.
module muxed_button_tap_hold_detector #(
    parameter int CHANNELS   = mbthd_pkg::CHANNELS_DEF,
    parameter int TIME_WIDTH = mbthd_pkg::TIME_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbthd_pkg::ADDR_W-1:0]  paddr,
    input  logic [mbthd_pkg::DATA_W-1:0]  pwdata,
    output logic [mbthd_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  mbthd_pkg::sample_t            sample_data,
    output logic                          result_valid,
    input  logic                          result_stall,
    output mbthd_pkg::result_t            result_data
);
    import mbthd_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_write;

    sample_t  sample_reg;
    logic     sample_vld_reg, sample_vld_next;
    result_t  result_reg;
    logic     result_vld_reg, result_vld_next;

    logic     out_free, fire, accept;
    logic     evt_hit;
    result_t  evt;

    // Register file: the word index is the address above the byte offset.
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx)
            REG_MIN_TAP:  prdata = cfg_reg.min_tap_ticks;
            REG_MIN_HOLD: prdata = cfg_reg.min_hold_ticks;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_MIN_TAP:  cfg_reg.min_tap_ticks  <= pwdata;
                REG_MIN_HOLD: cfg_reg.min_hold_ticks <= pwdata;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The request in the input register is processed as soon as the result
    // register can take whatever it produces, whether or not it produces one.
    assign out_free     = !result_vld_reg || !result_stall;
    assign fire         = sample_vld_reg && out_free;
    assign sample_stall = sample_vld_reg && !out_free;
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        sample_vld_next = sample_vld_reg;
        if (accept)
        begin
            sample_vld_next = 1'b1;
        end
        else if (fire)
        begin
            sample_vld_next = 1'b0;
        end

        result_vld_next = result_vld_reg;
        if (fire)
        begin
            result_vld_next = evt_hit;
        end
        else if (!result_stall)
        begin
            result_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_vld_reg <= 1'b0;
            result_vld_reg <= 1'b0;
        end
        else
        begin
            sample_vld_reg <= sample_vld_next;
            result_vld_reg <= result_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample_data;
        end
        if (fire && evt_hit)
        begin
            result_reg <= evt;
        end
    end

    mbthd_chan_bank #(
        .CHANNELS   (CHANNELS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .sample  (sample_reg),
        .cfg     (cfg_reg),
        .evt_hit (evt_hit),
        .evt     (evt)
    );

    assign result_valid = result_vld_reg;
    assign result_data  = result_reg;

endmodule

[hdl/mbthd_chan_bank.sv]
// Per-channel state bank of the tap/hold detector and its state update.
// Depends on mbthd_pkg.
module mbthd_chan_bank #(
    parameter int CHANNELS   = mbthd_pkg::CHANNELS_DEF,
    parameter int TIME_WIDTH = mbthd_pkg::TIME_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  mbthd_pkg::sample_t sample,
    input  mbthd_pkg::cfg_t   cfg,
    output logic              evt_hit,
    output mbthd_pkg::result_t evt
);
    import mbthd_pkg::*;

    localparam int IDX_W = $clog2(CHANNELS);
    localparam int CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

    logic [CHANNELS-1:0]   level_reg, level_next;
    logic [CHANNELS-1:0]   pend_reg, pend_next;
    logic [TIME_WIDTH-1:0] ref_reg  [CHANNELS];
    logic [TIME_WIDTH-1:0] ref_next [CHANNELS];

    logic                  sel_valid;
    logic [IDX_W-1:0]      sel_idx;
    logic [TIME_WIDTH-1:0] now;
    logic                  cur_level, cur_pend;
    logic [TIME_WIDTH-1:0] cur_ref, dt, hold_dt;
    logic                  tap, change, pend_mid, hold;
    logic                  new_level, new_pend;
    logic [TIME_WIDTH-1:0] new_ref;

    assign sel_valid = (int'(sample.channel) < CHANNELS);
    assign sel_idx   = IDX_W'(sample.channel);
    assign now       = TIME_WIDTH'(sample.now_ticks);
    assign cur_level = level_reg[sel_idx];
    assign cur_pend  = pend_reg[sel_idx];
    assign cur_ref   = ref_reg[sel_idx];

    // Release-side tap check runs on the state before the level update; the
    // hold check runs afterwards, with a fresh reference on a level change.
    always_comb
    begin
        dt       = now - cur_ref;
        tap      = !sample.pressed && cur_pend
                   && (CMP_W'(dt) >= CMP_W'(cfg.min_tap_ticks));
        change   = (cur_level != sample.pressed);
        pend_mid = change ? sample.pressed : cur_pend;
        hold_dt  = change ? '0 : dt;
        hold     = pend_mid && (CMP_W'(hold_dt) >= CMP_W'(cfg.min_hold_ticks));
        new_level = sample.pressed;
        new_pend  = pend_mid && !hold;
        new_ref   = (tap || change || hold) ? now : cur_ref;

        evt_hit = sel_valid && (tap || hold);
        evt.event_kind     = tap ? EVT_TAP : EVT_HOLD;
        evt.event_channel  = sample.channel;
        evt.duration_ticks = tap ? 32'(dt) : 32'(hold_dt);
    end

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            level_next[i] = level_reg[i];
            pend_next[i]  = pend_reg[i];
            ref_next[i]   = ref_reg[i];
            if (sel_valid && (sel_idx == IDX_W'(i)))
            begin
                level_next[i] = new_level;
                pend_next[i]  = new_pend;
                ref_next[i]   = new_ref;
            end
            else if (!level_reg[i])
            begin
                ref_next[i] = now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            pend_reg  <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                ref_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            level_reg <= level_next;
            pend_reg  <= pend_next;
            for (int i = 0; i < CHANNELS; i++)
            begin
                ref_reg[i] <= ref_next[i];
            end
        end
    end

endmodule

[hdl/mbthd_checker.sv]
// Port-level checker for the multiplexed button tap/hold detector.
// Depends on mbthd_pkg; bound to muxed_button_tap_hold_detector.
module mbthd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               sample_stall,
    input logic               result_valid,
    input logic               result_stall,
    input mbthd_pkg::result_t result_data
);

    // A stalled result stays offered with unchanged contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result_data)))
    else $error("stalled result dropped or changed");

    // The sample side only backs up when a result is waiting on a stalled receiver.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (result_valid && result_stall))
    else $error("sample stall without a blocked result");

    // No result is offered while reset is applied.
    assert property (@(posedge clk)
        !rst_n |-> !result_valid)
    else $error("result offered during reset");

endmodule

bind muxed_button_tap_hold_detector mbthd_checker u_mbthd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);
